FILE: hw/rtl/bcr_pkg.sv
// Shared types and constants for the button chord resolver.
// No dependencies; used by bcr_fsm and button_chord_resolver_core.
package bcr_pkg;

   localparam int unsigned ButtonsWidth  = 16;
   localparam int unsigned TimeWidth     = 64;
   localparam int unsigned WindowWidth   = 32;
   localparam int unsigned NibbleWidth   = 4;

   // Default key positions of the E group and of the two aux outputs.
   localparam int unsigned DefaultELsb      = 10;
   localparam int unsigned DefaultAuxYesBit = 14;
   localparam int unsigned DefaultAuxNoBit  = 15;

   localparam logic [WindowWidth-1:0] WindowReset = 32'd40000;

   // Request payload: buttons in the low bits, timestamp above.
   localparam int unsigned ReqDataWidth = ButtonsWidth + TimeWidth;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_GATHER  = 2'd1,
      PH_RAW     = 2'd2,
      PH_LATCHED = 2'd3
   } phase_type;

   // Chord codes of the gathered E nibble.
   localparam logic [NibbleWidth-1:0] ChordYes  = 4'h3;
   localparam logic [NibbleWidth-1:0] ChordNo   = 4'hC;
   localparam logic [NibbleWidth-1:0] ChordBoth = 4'hF;

endpackage

FILE: hw/rtl/button_chord_resolver_core.sv
// Top level of the button chord resolver: input register, chord FSM, result register.
// Depends on bcr_pkg and bcr_fsm.
//
//   Channel  Direction  Payload
//   req_     in         tdata[15:0] buttons_in, tdata[79:16] now_us
//   rsp_     out        tdata[15:0] buttons_out
//   csr_     in         data[31:0] window_length_us
//
// One sample per clock cycle is sustained while rsp_ is not stalled; a sample passes from its
// req_ transfer through the input register and then the result register to its rsp_ result.
// The chord state advances when a sample moves from the input register to the result register.
// Reset is synchronous, clears the phase and both valid flags and sets the window register to its default.
// A stalled rsp_ side holds the result; the input register still takes one more sample.
module button_chord_resolver_core #(
   parameter int unsigned E_LSB       = bcr_pkg::DefaultELsb,
   parameter int unsigned AUX_YES_BIT = bcr_pkg::DefaultAuxYesBit,
   parameter int unsigned AUX_NO_BIT  = bcr_pkg::DefaultAuxNoBit
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bcr_pkg::ReqDataWidth-1:0]    req_tdata,  // buttons_in, now_us
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bcr_pkg::ButtonsWidth-1:0]    rsp_tdata,  // buttons_out
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bcr_pkg::WindowWidth-1:0]     csr_data    // window_length_us
);

   logic                                in_valid_ff, in_valid_in;
   logic [bcr_pkg::ButtonsWidth-1:0]    in_buttons_ff;
   logic [bcr_pkg::TimeWidth-1:0]       in_now_ff;
   logic                                out_valid_ff, out_valid_in;
   logic [bcr_pkg::ButtonsWidth-1:0]    out_data_ff;
   logic [bcr_pkg::WindowWidth-1:0]     window_ff;
   logic [bcr_pkg::ButtonsWidth-1:0]    resolved;
   logic                                advance;
   logic                                take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   bcr_fsm #(
      .E_LSB       (E_LSB),
      .AUX_YES_BIT (AUX_YES_BIT),
      .AUX_NO_BIT  (AUX_NO_BIT)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .buttons     (in_buttons_ff),
      .now_us      (in_now_ff),
      .window_us   (window_ff),
      .buttons_out (resolved)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= bcr_pkg::WindowReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            window_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_buttons_ff <= req_tdata[bcr_pkg::ButtonsWidth-1:0];
         in_now_ff     <= req_tdata[bcr_pkg::ReqDataWidth-1:bcr_pkg::ButtonsWidth];
      end
      if (advance) begin
         out_data_ff <= resolved;
      end
   end

endmodule

FILE: hw/rtl/bcr_fsm.sv
// Chord state machine: gathers E-bits, times the window and resolves each sample.
// Depends on bcr_pkg.
module bcr_fsm #(
   parameter int unsigned E_LSB       = bcr_pkg::DefaultELsb,
   parameter int unsigned AUX_YES_BIT = bcr_pkg::DefaultAuxYesBit,
   parameter int unsigned AUX_NO_BIT  = bcr_pkg::DefaultAuxNoBit
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [bcr_pkg::ButtonsWidth-1:0]    buttons,
   input  logic [bcr_pkg::TimeWidth-1:0]       now_us,
   input  logic [bcr_pkg::WindowWidth-1:0]     window_us,
   output logic [bcr_pkg::ButtonsWidth-1:0]    buttons_out
);

   localparam logic [bcr_pkg::ButtonsWidth-1:0] EField =
      bcr_pkg::ButtonsWidth'(16'hF) << E_LSB;
   localparam logic [bcr_pkg::ButtonsWidth-1:0] AuxYes =
      bcr_pkg::ButtonsWidth'(1) << AUX_YES_BIT;
   localparam logic [bcr_pkg::ButtonsWidth-1:0] AuxNo =
      bcr_pkg::ButtonsWidth'(1) << AUX_NO_BIT;

   bcr_pkg::phase_type                  phase_ff, phase_in;
   logic [bcr_pkg::NibbleWidth-1:0]     gathered_ff, gathered_in;
   logic [bcr_pkg::ButtonsWidth-1:0]    held_ff, held_in;
   logic [bcr_pkg::TimeWidth-1:0]       window_end_ff, window_end_in;

   logic [bcr_pkg::ButtonsWidth-1:0]    rest;
   logic [bcr_pkg::ButtonsWidth-1:0]    ebits;
   logic [bcr_pkg::NibbleWidth-1:0]     nib;
   logic [bcr_pkg::NibbleWidth-1:0]     merged;
   logic [bcr_pkg::ButtonsWidth-1:0]    chord;
   logic                                expired;

   function automatic logic [bcr_pkg::ButtonsWidth-1:0] chord_of(
      input logic [bcr_pkg::NibbleWidth-1:0] n
   );
      logic [bcr_pkg::ButtonsWidth-1:0] r;
      case (n)
         bcr_pkg::ChordYes:  r = AuxYes;
         bcr_pkg::ChordNo:   r = AuxNo;
         bcr_pkg::ChordBoth: r = AuxYes | AuxNo;
         default:            r = (bcr_pkg::ButtonsWidth'(n) << E_LSB) & EField;
      endcase
      return r;
   endfunction

   assign rest    = buttons & ~EField;
   assign ebits   = buttons & EField;
   assign nib     = bcr_pkg::NibbleWidth'(ebits >> E_LSB);
   assign merged  = gathered_ff | nib;
   assign chord   = chord_of(merged);
   assign expired = now_us >= window_end_ff;

   always_comb begin
      phase_in      = phase_ff;
      gathered_in   = gathered_ff;
      held_in       = held_ff;
      window_end_in = window_end_ff;
      buttons_out   = rest;
      unique case (phase_ff)
         bcr_pkg::PH_IDLE: begin
            // E-bits are suppressed until the window decides what they mean.
            if (nib != '0) begin
               gathered_in   = nib;
               window_end_in = now_us + bcr_pkg::TimeWidth'(window_us);
               phase_in      = bcr_pkg::PH_GATHER;
            end
         end
         bcr_pkg::PH_GATHER: begin
            gathered_in = merged;
            if (nib == '0) begin
               buttons_out = rest | chord;
               phase_in    = bcr_pkg::PH_IDLE;
            end else if (expired) begin
               held_in = chord;
               if ((chord & (AuxYes | AuxNo)) != '0) begin
                  phase_in    = bcr_pkg::PH_LATCHED;
                  buttons_out = rest | chord;
               end else begin
                  phase_in    = bcr_pkg::PH_RAW;
                  buttons_out = rest | ebits;
               end
            end
         end
         bcr_pkg::PH_RAW: begin
            if (nib == '0) begin
               phase_in = bcr_pkg::PH_IDLE;
            end
            buttons_out = rest | ebits;
         end
         bcr_pkg::PH_LATCHED: begin
            if (nib == '0) begin
               phase_in = bcr_pkg::PH_IDLE;
            end else begin
               buttons_out = rest | held_ff;
            end
         end
         default: begin
            phase_in = bcr_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bcr_pkg::PH_IDLE;
         gathered_ff   <= '0;
         held_ff       <= '0;
         window_end_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         gathered_ff   <= gathered_in;
         held_ff       <= held_in;
         window_end_ff <= window_end_in;
      end
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_chord_resolver_core: taps, held chords, deadlines and
// window settings, checked against an in-bench model of the chord logic. Depends on bcr_pkg.
module tb_top;

   localparam int unsigned ELsb        = bcr_pkg::DefaultELsb;
   localparam logic [15:0] EMask       = 16'hF << bcr_pkg::DefaultELsb;
   localparam logic [15:0] AuxYesMask  = 16'h1 << bcr_pkg::DefaultAuxYesBit;
   localparam logic [15:0] AuxNoMask   = 16'h1 << bcr_pkg::DefaultAuxNoBit;
   localparam int unsigned CycleLimit  = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bcr_pkg::ReqDataWidth-1:0] req_tdata = '0;  // buttons_in, now_us
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [bcr_pkg::ButtonsWidth-1:0] rsp_tdata;      // buttons_out
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bcr_pkg::WindowWidth-1:0] csr_data = '0;   // window_length_us

   // Model state of the chord logic.
   bcr_pkg::phase_type chord_phase = bcr_pkg::PH_IDLE;
   logic [3:0]  pressed_nib = '0;
   logic [15:0] latched_value = '0;
   logic [63:0] deadline_us = '0;
   logic [31:0] gather_window = bcr_pkg::WindowReset;

   logic [15:0] expected_buttons[$];
   int unsigned mismatches = 0;
   int unsigned sample_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b1;
   logic [63:0] stamp_us = '0;

   button_chord_resolver_core DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [15:0] chord_value(input logic [3:0] nib);
      case (nib)
         bcr_pkg::ChordYes:  return AuxYesMask;
         bcr_pkg::ChordNo:   return AuxNoMask;
         bcr_pkg::ChordBoth: return AuxYesMask | AuxNoMask;
         default:            return (16'(nib) << ELsb) & EMask;
      endcase
   endfunction

   // Advances the model by one sample and returns the buttons it should put out.
   function automatic logic [15:0] resolve_sample(input logic [15:0] buttons,
                                                  input logic [63:0] now_us);
      logic [15:0] rest;
      logic [15:0] ebits;
      logic [15:0] result;
      logic [3:0]  nib;
      rest   = buttons & ~EMask;
      ebits  = buttons & EMask;
      nib    = buttons[ELsb +: 4];
      result = rest;
      case (chord_phase)
         bcr_pkg::PH_IDLE: begin
            if (nib != 0) begin
               pressed_nib = nib;
               deadline_us = now_us + {32'd0, gather_window};
               chord_phase = bcr_pkg::PH_GATHER;
            end
         end
         bcr_pkg::PH_GATHER: begin
            pressed_nib = pressed_nib | nib;
            if (nib == 0) begin
               result      = rest | chord_value(pressed_nib);
               chord_phase = bcr_pkg::PH_IDLE;
            end else if (now_us >= deadline_us) begin
               latched_value = chord_value(pressed_nib);
               if ((latched_value & (AuxYesMask | AuxNoMask)) != 0) begin
                  chord_phase = bcr_pkg::PH_LATCHED;
                  result      = rest | latched_value;
               end else begin
                  chord_phase = bcr_pkg::PH_RAW;
                  result      = rest | ebits;
               end
            end
         end
         bcr_pkg::PH_RAW: begin
            if (nib == 0) chord_phase = bcr_pkg::PH_IDLE;
            result = rest | ebits;
         end
         default: begin
            if (nib == 0) chord_phase = bcr_pkg::PH_IDLE;
            else result = rest | latched_value;
         end
      endcase
      return result;
   endfunction

   function automatic logic [15:0] compose_buttons(input logic [15:0] rest,
                                                   input logic [3:0] nib);
      logic [15:0] buttons;
      buttons = rest;
      buttons[ELsb +: 4] = nib;
      return buttons;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
   endtask

   // Result side: random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 12) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_buttons.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = expected_buttons.pop_front();
            if (rsp_tdata !== want)
               report_mismatch($sformatf("buttons_out expected %h, got %h", want, rsp_tdata));
         end
      end
   end

   // Sends one sample; tvalid is left high so back-to-back transfers need no second assignment.
   task automatic send_sample(input logic [15:0] buttons, input logic [63:0] now_us);
      if (idle_on && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now_us, buttons};
      do @(posedge clock); while (!req_tready);
      expected_buttons.push_back(resolve_sample(buttons, now_us));
      sample_count++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_buttons.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [31:0] window);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data  <= window;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      gather_window = window;
   endtask

   task automatic test_default_window_taps();
      send_sample(16'hC3FF, 64'd0);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordYes), 64'd100);
      send_sample(16'h0000, 64'd200);
      send_sample(compose_buttons(16'h0001, 4'h4), 64'd300);
      send_sample(compose_buttons(16'h0002, bcr_pkg::ChordNo), 64'd400);
      send_sample(16'h0000, 64'd500);
      send_sample(compose_buttons(16'h8000, bcr_pkg::ChordBoth), 64'd1000);
      send_sample(16'hC3FF, 64'd1100);
      send_sample(compose_buttons(16'h00F0, 4'h5), 64'd2000);
      send_sample(16'h0000, 64'd2100);
   endtask

   // Expiry exactly at the deadline, latched and raw holds, and time running backwards.
   task automatic test_held_chords();
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordYes), 64'd10000);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordYes), 64'd49999);
      send_sample(compose_buttons(16'h0300, bcr_pkg::ChordYes), 64'd50000);
      send_sample(compose_buttons(16'h0000, 4'h1), 64'd50001);
      send_sample(16'h0003, 64'd50002);
      send_sample(compose_buttons(16'h0000, 4'h1), 64'd60000);
      send_sample(compose_buttons(16'h0000, 4'h1), 64'd100000);
      send_sample(compose_buttons(16'h4000, 4'h2), 64'd100001);
      send_sample(16'h0000, 64'd100002);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordNo), 64'd5000);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordNo), 64'd100);
      send_sample(16'h0000, 64'd101);
      // The deadline wraps past the top of the timestamp range and expires at once.
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordBoth), 64'hFFFF_FFFF_FFFF_FFF0);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordBoth), 64'hFFFF_FFFF_FFFF_FFF1);
      send_sample(16'h0000, 64'd0);
   endtask

   task automatic test_window_extremes();
      write_window(32'd0);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordYes), 64'd500);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordYes), 64'd500);
      send_sample(16'h0000, 64'd501);
      send_sample(compose_buttons(16'h0000, 4'h2), 64'd700);
      send_sample(compose_buttons(16'h0000, 4'h2), 64'd700);
      send_sample(16'h0000, 64'd701);
      write_window(32'hFFFF_FFFF);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordBoth), 64'd0);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordBoth), 64'hFFFF_FFFE);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordBoth), 64'hFFFF_FFFF);
      send_sample(16'h0000, 64'h1_0000_0000);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordNo), 64'hFFFF_FFFF_0000_0001);
      send_sample(compose_buttons(16'h0000, bcr_pkg::ChordNo), 64'd5);
      send_sample(16'h0000, 64'd6);
   endtask

   // Mostly press-and-release sequences with random content, some left held, some noise.
   task automatic run_random_phase(input logic [31:0] window, input int unsigned items,
                                   input bit hold_off);
      int unsigned first;
      int unsigned k;
      int unsigned holds;
      int unsigned step_cap;
      bit          paused;
      logic [3:0]  target;
      logic [3:0]  nib;
      write_window(window);
      first    = sample_count;
      paused   = 1'b0;
      step_cap = (window == 0) ? 4 : window / 3 + 1;
      while (sample_count - first < items) begin
         if (hold_off && !paused && sample_count - first >= items / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 49) == 0) stamp_us = ~64'($urandom_range(0, step_cap));
         else if ($urandom_range(0, 29) == 0) stamp_us -= $urandom_range(0, step_cap);
         if ($urandom_range(0, 4) == 0) begin
            send_sample(16'($urandom), {$urandom, $urandom});
         end else begin
            case ($urandom_range(0, 3))
               0:       target = bcr_pkg::ChordYes;
               1:       target = bcr_pkg::ChordNo;
               2:       target = bcr_pkg::ChordBoth;
               default: target = 4'($urandom_range(1, 15));
            endcase
            holds = $urandom_range(1, 6);
            for (k = 0; k < holds; k++) begin
               nib = (k == holds - 1) ? target : target & 4'($urandom);
               if (nib == 0) nib = target;
               stamp_us += $urandom_range(0, step_cap);
               send_sample(compose_buttons(16'($urandom), nib), stamp_us);
            end
            if ($urandom_range(0, 9) != 0) begin
               stamp_us += $urandom_range(0, step_cap);
               send_sample(compose_buttons(16'($urandom), 4'h0), stamp_us);
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(32'd1, 300, 1'b0);
      run_random_phase(32'($urandom_range(2, 400)), 300, 1'b1);
      idle_on = 1'b0;
      run_random_phase(32'($urandom), 300, 1'b0);
      idle_on = 1'b1;
      run_random_phase(32'hFFFF_FFFF, 300, 1'b0);
      run_random_phase(32'($urandom_range(0, 2000)), 300, 1'b0);
      run_random_phase(32'd0, 250, 1'b0);
   endtask

   task automatic test_quiet_tail();
      idle_on = 1'b0;
      run_random_phase(32'd90, 100, 1'b0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_default_window_taps();
      test_held_chords();
      test_window_extremes();
      test_random_traffic();
      test_quiet_tail();
      wait_for_results();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
